// ----- sv/pst_pkg.sv -----
// Shared types, codes and constants for the PE section table lookup block.
package pst_pkg;

    typedef enum logic [2:0] {
        ST_FOUND     = 3'd0,
        ST_BAD_MZ    = 3'd1,
        ST_BAD_PE    = 3'd2,
        ST_BAD_COUNT = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_TRUNCATED = 3'd5
    } status_t;

    typedef struct packed {
        logic        valid;
        status_t     status;
        logic [31:0] section_offset;
        logic [31:0] section_size;
    } pst_result_t;

    localparam logic CFG_WANTED_NAME  = 1'b0;
    localparam logic CFG_MAX_SECTIONS = 1'b1;

    localparam logic [15:0] MAX_SECT_RST = 16'd200;
    localparam logic [32:0] POS_MAX      = 33'h1_FFFF_FFFF;
    localparam logic [32:0] LFANEW_AT    = 33'h3C;
    localparam logic [32:0] HDR_AREA_END = 33'h40;
    localparam logic [31:0] HDR_MIN      = 32'd64;
    localparam logic [32:0] HDR_LEN      = 33'd24;
    localparam logic [5:0]  ROW_LAST     = 6'd39;

    localparam logic [7:0] CHAR_M = 8'h4D;
    localparam logic [7:0] CHAR_Z = 8'h5A;
    localparam logic [7:0] CHAR_P = 8'h50;
    localparam logic [7:0] CHAR_E = 8'h45;

endpackage

// ----- sv/pe_section_table_lookup.sv -----
// Top level: input beat register, parser, result register and config registers.
//
//  channel  | dir | handshake        | payload
//  s_       | in  | s_tvalid/tready  | s_tdata[7:0] data_byte, s_tlast last_byte
//  m_       | out | m_tvalid/tready  | m_tdata status, section_offset, section_size
//  cfg_     | in  | cfg_wr_en        | cfg_wr_index, cfg_wr_data
//
// One beat per cycle while s_tready is high; a result goes out from the result register.
// The rate is set by the per-byte parser step between the input and result registers.
// Reset clears the parser and the beat registers; wanted_name resets to zero and
// max_sections to 200. A stalled m_ side holds the result and backs up s_tready
// only once both the input and result registers are full.
module pe_section_table_lookup
    import pst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [2:0] status, [34:3] section_offset,
                                   // [66:35] section_size, [71:67] zero
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [63:0] cfg_wr_data
);

    logic [63:0] wanted_name_reg;
    logic [15:0] max_sect_reg;
    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        load_ready;
    logic        step;
    pst_result_t result;
    status_t     out_status;
    logic [31:0] out_offset;
    logic [31:0] out_size;

    assign step     = in_valid_reg && load_ready;
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_name_reg <= '0;
            max_sect_reg    <= MAX_SECT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_WANTED_NAME:  wanted_name_reg <= cfg_wr_data;
                CFG_MAX_SECTIONS: max_sect_reg    <= cfg_wr_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    pst_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .data_byte    (in_byte_reg),
        .last_byte    (in_last_reg),
        .wanted_name  (wanted_name_reg),
        .max_sections (max_sect_reg),
        .result       (result)
    );

    pst_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .result     (result),
        .load_ready (load_ready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (out_status),
        .out_offset (out_offset),
        .out_size   (out_size)
    );

    assign m_tdata = {5'b0, out_size, out_offset, out_status};

    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (out_status == ST_FOUND || out_status == ST_BAD_MZ ||
                      out_status == ST_BAD_PE || out_status == ST_BAD_COUNT ||
                      out_status == ST_NOT_FOUND || out_status == ST_TRUNCATED))
        else $error("result status out of range");

    a_zero_on_fail: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_status != ST_FOUND) |-> (out_offset == 32'd0 && out_size == 32'd0))
        else $error("nonzero section fields on a failed lookup");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_byte_reg)
                                     && $stable(in_last_reg)))
        else $error("input beat register lost a pending beat");

    a_no_step_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !step)
        else $error("parser stepped while result register was blocked");

endmodule

// ----- sv/pst_parser.sv -----
// Byte-at-a-time header and section table parser with decision logic.
module pst_parser
    import pst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [63:0] wanted_name,
    input  logic [15:0] max_sections,
    output pst_result_t result
);

    logic [32:0] byte_pos_reg,  byte_pos_next;
    logic [31:0] hdr_off_reg,   hdr_off_next;
    logic [15:0] sec_cnt_reg,   sec_cnt_next;
    logic [15:0] opt_size_reg,  opt_size_next;
    logic [15:0] row_num_reg,   row_num_next;
    logic [5:0]  row_byte_reg,  row_byte_next;
    logic        name_eq_reg,   name_eq_next;
    logic [31:0] size_cap_reg,  size_cap_next;
    logic [31:0] ptr_cap_reg,   ptr_cap_next;
    logic        finished_reg,  finished_next;
    logic [32:0] tbl_start_reg, tbl_start_next;

    logic        dec_valid;
    status_t     dec_status;
    logic [32:0] rel;
    logic        pos_ge_hdr;
    logic [31:0] hdr_full;
    logic [15:0] row_num_inc;

    assign rel         = byte_pos_reg - {1'b0, hdr_off_reg};
    assign pos_ge_hdr  = byte_pos_reg >= {1'b0, hdr_off_reg};
    assign hdr_full    = {data_byte, hdr_off_reg[23:0]};
    assign row_num_inc = row_num_reg + 16'd1;

    always_comb begin
        byte_pos_next  = byte_pos_reg;
        hdr_off_next   = hdr_off_reg;
        sec_cnt_next   = sec_cnt_reg;
        opt_size_next  = opt_size_reg;
        row_num_next   = row_num_reg;
        row_byte_next  = row_byte_reg;
        name_eq_next   = name_eq_reg;
        size_cap_next  = size_cap_reg;
        ptr_cap_next   = ptr_cap_reg;
        finished_next  = finished_reg;
        tbl_start_next = tbl_start_reg;
        dec_valid      = 1'b0;
        dec_status     = ST_FOUND;

        if (!finished_reg) begin
            if (byte_pos_reg == 33'd0 && data_byte != CHAR_M) begin
                dec_valid  = 1'b1;
                dec_status = ST_BAD_MZ;
            end else if (byte_pos_reg == 33'd1 && data_byte != CHAR_Z) begin
                dec_valid  = 1'b1;
                dec_status = ST_BAD_MZ;
            end else if (byte_pos_reg >= LFANEW_AT && byte_pos_reg < HDR_AREA_END) begin
                hdr_off_next[{byte_pos_reg[1:0], 3'b000} +: 8] = data_byte;
                if (byte_pos_reg[1:0] == 2'd3 && hdr_full < HDR_MIN) begin
                    dec_valid  = 1'b1;
                    dec_status = ST_BAD_PE;
                end
            end else if (byte_pos_reg >= HDR_AREA_END && pos_ge_hdr) begin
                if (rel < HDR_LEN) begin
                    case (rel[4:0])
                        5'd0: begin
                            if (data_byte != CHAR_P) begin
                                dec_valid  = 1'b1;
                                dec_status = ST_BAD_PE;
                            end
                        end
                        5'd1: begin
                            if (data_byte != CHAR_E) begin
                                dec_valid  = 1'b1;
                                dec_status = ST_BAD_PE;
                            end
                        end
                        5'd2, 5'd3: begin
                            if (data_byte != 8'd0) begin
                                dec_valid  = 1'b1;
                                dec_status = ST_BAD_PE;
                            end
                        end
                        5'd6:  sec_cnt_next[7:0]   = data_byte;
                        5'd7:  sec_cnt_next[15:8]  = data_byte;
                        5'd20: opt_size_next[7:0]  = data_byte;
                        5'd21: opt_size_next[15:8] = data_byte;
                        5'd22: begin
                            tbl_start_next = {1'b0, hdr_off_reg} + HDR_LEN
                                             + {17'b0, opt_size_reg};
                        end
                        5'd23: begin
                            if (sec_cnt_reg == 16'd0 || sec_cnt_reg > max_sections) begin
                                dec_valid  = 1'b1;
                                dec_status = ST_BAD_COUNT;
                            end
                        end
                        default: ;
                    endcase
                end else if (byte_pos_reg >= tbl_start_reg) begin
                    if (row_byte_reg < 6'd8) begin
                        if (wanted_name[{row_byte_reg[2:0], 3'b000} +: 8] != data_byte) begin
                            name_eq_next = 1'b0;
                        end
                    end else if (row_byte_reg >= 6'd16 && row_byte_reg < 6'd20) begin
                        size_cap_next[{row_byte_reg[1:0], 3'b000} +: 8] = data_byte;
                    end else if (row_byte_reg >= 6'd20 && row_byte_reg < 6'd24) begin
                        ptr_cap_next[{row_byte_reg[1:0], 3'b000} +: 8] = data_byte;
                    end
                    if (row_byte_reg != ROW_LAST) begin
                        row_byte_next = row_byte_reg + 6'd1;
                    end else if (name_eq_reg) begin
                        dec_valid  = 1'b1;
                        dec_status = ST_FOUND;
                    end else begin
                        row_byte_next = 6'd0;
                        name_eq_next  = 1'b1;
                        row_num_next  = row_num_inc;
                        if (row_num_inc >= sec_cnt_reg) begin
                            dec_valid  = 1'b1;
                            dec_status = ST_NOT_FOUND;
                        end
                    end
                end
            end
            if (!dec_valid && last_byte) begin
                dec_valid  = 1'b1;
                dec_status = ST_TRUNCATED;
            end
        end

        if (byte_pos_reg != POS_MAX) begin
            byte_pos_next = byte_pos_reg + 33'd1;
        end
        if (dec_valid) begin
            finished_next = 1'b1;
        end

        if (last_byte) begin
            byte_pos_next  = '0;
            hdr_off_next   = '0;
            sec_cnt_next   = '0;
            opt_size_next  = '0;
            row_num_next   = '0;
            row_byte_next  = '0;
            name_eq_next   = 1'b1;
            size_cap_next  = '0;
            ptr_cap_next   = '0;
            finished_next  = 1'b0;
            tbl_start_next = '0;
        end
    end

    always_comb begin
        result.valid          = step && dec_valid;
        result.status         = dec_status;
        result.section_offset = (dec_status == ST_FOUND) ? ptr_cap_reg : 32'd0;
        result.section_size   = (dec_status == ST_FOUND) ? size_cap_reg : 32'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_pos_reg  <= '0;
            hdr_off_reg   <= '0;
            sec_cnt_reg   <= '0;
            opt_size_reg  <= '0;
            row_num_reg   <= '0;
            row_byte_reg  <= '0;
            name_eq_reg   <= 1'b1;
            size_cap_reg  <= '0;
            ptr_cap_reg   <= '0;
            finished_reg  <= 1'b0;
            tbl_start_reg <= '0;
        end else if (step) begin
            byte_pos_reg  <= byte_pos_next;
            hdr_off_reg   <= hdr_off_next;
            sec_cnt_reg   <= sec_cnt_next;
            opt_size_reg  <= opt_size_next;
            row_num_reg   <= row_num_next;
            row_byte_reg  <= row_byte_next;
            name_eq_reg   <= name_eq_next;
            size_cap_reg  <= size_cap_next;
            ptr_cap_reg   <= ptr_cap_next;
            finished_reg  <= finished_next;
            tbl_start_reg <= tbl_start_next;
        end
    end

endmodule

// ----- sv/pst_out_buf.sv -----
// Result register in front of the master-side stream.
module pst_out_buf
    import pst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  pst_result_t result,
    output logic        load_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output status_t     out_status,
    output logic [31:0] out_offset,
    output logic [31:0] out_size
);

    logic        valid_reg;
    status_t     status_reg;
    logic [31:0] offset_reg;
    logic [31:0] size_reg;

    assign load_ready = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_offset = offset_reg;
    assign out_size   = size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load_ready) begin
            valid_reg <= result.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_ready && result.valid) begin
            status_reg <= result.status;
            offset_reg <= result.section_offset;
            size_reg   <= result.section_size;
        end
    end

endmodule

// ----- tb/pe_section_table_lookup_tb.sv -----
// Testbench for pe_section_table_lookup: streams generated PE images and checks lookup results.
`timescale 1ns / 100ps

module pe_section_table_lookup_tb;
    import pst_pkg::*;

    typedef enum logic [1:0] {
        BY_MODEL   = 2'd0,
        TYPED_HIT  = 2'd1,
        TYPED_NONE = 2'd2
    } exp_mode_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        exp_mode_t  mode;
        status_t    st;
    } file_beat_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] offset;
        logic [31:0] size;
    } lookup_t;

    typedef enum int {
        FK_MATCH, FK_MISS, FK_SMALL_HDR, FK_BAD_SIG, FK_BAD_COUNT,
        FK_CUT, FK_CUT_IN_ROW, FK_BAD_MZ, FK_NOISE
    } file_kind_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_index = CFG_WANTED_NAME;
    logic [63:0] cfg_wr_data = 64'h0;

    pe_section_table_lookup uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data)
    );

    // parser mirror
    logic [63:0] want_name = 64'h0;
    logic [15:0] max_sect  = MAX_SECT_RST;
    logic [32:0] prs_pos;
    logic [31:0] prs_hoff;
    logic [15:0] prs_cnt;
    logic [15:0] prs_opt;
    logic [15:0] prs_row;
    logic [5:0]  prs_rowb;
    logic        prs_name_eq;
    logic [31:0] prs_size;
    logic [31:0] prs_ptr;
    logic        prs_done;

    file_beat_t beat_q[$];
    lookup_t    pending_lookups[$];
    file_beat_t cur_beat = '0;
    file_beat_t nxt_beat;
    bit         calm = 1'b0;
    int         hold_off = 0;
    int         errors = 0;
    int         n_beats = 0;
    int         n_results = 0;
    int         n_files = 0;

    file_beat_t dir_rows [21] = '{
        '{8'h4D, 1'b1, TYPED_HIT,  ST_TRUNCATED},
        '{8'h58, 1'b0, TYPED_HIT,  ST_BAD_MZ},
        '{8'h59, 1'b0, TYPED_NONE, ST_FOUND},
        '{8'hFF, 1'b1, TYPED_NONE, ST_FOUND},
        '{8'h4D, 1'b0, TYPED_NONE, ST_FOUND},
        '{8'h5A, 1'b1, TYPED_HIT,  ST_TRUNCATED},
        '{8'h00, 1'b1, TYPED_HIT,  ST_BAD_MZ},
        '{8'h4D, 1'b0, TYPED_NONE, ST_FOUND},
        '{8'h00, 1'b0, TYPED_HIT,  ST_BAD_MZ},
        '{8'h4D, 1'b0, TYPED_NONE, ST_FOUND},
        '{8'hFF, 1'b1, TYPED_NONE, ST_FOUND},
        '{8'h4D, 1'b0, TYPED_NONE, ST_FOUND},
        '{8'h5A, 1'b0, TYPED_NONE, ST_FOUND},
        '{8'h00, 1'b0, TYPED_NONE, ST_FOUND},
        '{8'hFF, 1'b0, TYPED_NONE, ST_FOUND},
        '{8'hAA, 1'b0, TYPED_NONE, ST_FOUND},
        '{8'h55, 1'b1, TYPED_HIT,  ST_TRUNCATED},
        '{8'hFF, 1'b1, TYPED_HIT,  ST_BAD_MZ},
        '{8'h4D, 1'b0, BY_MODEL,   ST_FOUND},
        '{8'h5A, 1'b0, BY_MODEL,   ST_FOUND},
        '{8'h3C, 1'b1, BY_MODEL,   ST_FOUND}
    };

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5000000;
        $display("timeout at %0t, %0d lookups pending", $time, pending_lookups.size());
        $display("FAILURE");
        $finish;
    end

    function automatic void restart_parser();
        prs_pos     = '0;
        prs_hoff    = '0;
        prs_cnt     = '0;
        prs_opt     = '0;
        prs_row     = '0;
        prs_rowb    = '0;
        prs_name_eq = 1'b1;
        prs_size    = '0;
        prs_ptr     = '0;
        prs_done    = 1'b0;
    endfunction

    // -1 when the byte decides nothing
    function automatic int eat_byte(input logic [7:0] d);
        logic [32:0] rel;
        int          k;
        if (prs_pos == 0 && d != CHAR_M) return int'(ST_BAD_MZ);
        if (prs_pos == 1 && d != CHAR_Z) return int'(ST_BAD_MZ);
        if (prs_pos >= LFANEW_AT && prs_pos < LFANEW_AT + 4) begin
            prs_hoff[8*int'(prs_pos[1:0]) +: 8] = d;
            if (prs_pos == LFANEW_AT + 3 && prs_hoff < HDR_MIN) return int'(ST_BAD_PE);
            return -1;
        end
        if (prs_pos < HDR_AREA_END) return -1;
        if (prs_pos < {1'b0, prs_hoff}) return -1;
        rel = prs_pos - {1'b0, prs_hoff};
        if (rel < HDR_LEN) begin
            if (rel == 0 && d != CHAR_P) return int'(ST_BAD_PE);
            if (rel == 1 && d != CHAR_E) return int'(ST_BAD_PE);
            if ((rel == 2 || rel == 3) && d != 8'h00) return int'(ST_BAD_PE);
            if (rel == 6) prs_cnt[7:0] = d;
            if (rel == 7) prs_cnt[15:8] = d;
            if (rel == 20) prs_opt[7:0] = d;
            if (rel == 21) prs_opt[15:8] = d;
            if (rel == HDR_LEN - 1 && (prs_cnt == 0 || prs_cnt > max_sect))
                return int'(ST_BAD_COUNT);
            return -1;
        end
        if (rel < HDR_LEN + {17'b0, prs_opt}) return -1;
        k = int'(prs_rowb);
        if (k < 8) begin
            if (want_name[8*k +: 8] != d) prs_name_eq = 1'b0;
        end else if (k >= 16 && k < 20) begin
            prs_size[8*(k-16) +: 8] = d;
        end else if (k >= 20 && k < 24) begin
            prs_ptr[8*(k-20) +: 8] = d;
        end
        if (prs_rowb < ROW_LAST) begin
            prs_rowb = prs_rowb + 1'b1;
            return -1;
        end
        if (prs_name_eq) return int'(ST_FOUND);
        prs_rowb    = '0;
        prs_name_eq = 1'b1;
        prs_row     = prs_row + 1'b1;
        if (prs_row >= prs_cnt) return int'(ST_NOT_FOUND);
        return -1;
    endfunction

    function automatic bit parse_file_byte(input logic [7:0] d, input logic last,
                                           output lookup_t r);
        int st;
        st = -1;
        r  = '0;
        if (!prs_done) st = eat_byte(d);
        if (prs_pos != POS_MAX) prs_pos = prs_pos + 1'b1;
        if (st < 0 && last && !prs_done) st = int'(ST_TRUNCATED);
        if (st >= 0) begin
            prs_done = 1'b1;
            r.status = status_t'(st);
            r.offset = (st == int'(ST_FOUND)) ? prs_ptr : 32'h0;
            r.size   = (st == int'(ST_FOUND)) ? prs_size : 32'h0;
        end
        if (last) restart_parser();
        return st >= 0;
    endfunction

    initial restart_parser();

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (beat_q.size() != 0 && (calm || $urandom_range(0, 99) >= 28)) begin
                nxt_beat = beat_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt_beat.data;
                s_tlast  <= nxt_beat.last;
                cur_beat <= nxt_beat;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= 28);
        end
    end

    // predict on input beats, check result beats
    always @(posedge aclk) begin
        lookup_t pred;
        lookup_t want;
        bit      got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                got = parse_file_byte(cur_beat.data, cur_beat.last, pred);
                n_beats++;
                if (cur_beat.mode == TYPED_HIT) begin
                    pending_lookups.push_back('{cur_beat.st, 32'h0, 32'h0});
                    n_results++;
                end else if (cur_beat.mode == BY_MODEL && got) begin
                    pending_lookups.push_back(pred);
                    n_results++;
                end
            end
            if (m_tvalid && m_tready) begin
                if (pending_lookups.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, m_tdata);
                    errors++;
                end else begin
                    want = pending_lookups.pop_front();
                    if (m_tdata[2:0] != want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_tdata[2:0]);
                        errors++;
                    end
                    if (m_tdata[34:3] != want.offset) begin
                        $display("%0t: section_offset expected %h actual %h",
                                 $time, want.offset, m_tdata[34:3]);
                        errors++;
                    end
                    if (m_tdata[66:35] != want.size) begin
                        $display("%0t: section_size expected %h actual %h",
                                 $time, want.size, m_tdata[66:35]);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic idx, input logic [63:0] val);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        if (idx == CFG_WANTED_NAME) want_name = val;
        else max_sect = val[15:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (beat_q.size() != 0 || s_tvalid || pending_lookups.size() != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic logic [7:0] nz_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic queue_file(input file_kind_t kind);
        logic [7:0] img[$];
        int h, opt, n, hit, cnt, len, i, r, b, row0;
        logic [7:0] v;
        img = {};
        h   = (kind == FK_SMALL_HDR) ? $urandom_range(0, 63) : 64 + $urandom_range(0, 3);
        opt = $urandom_range(0, 4);
        n   = $urandom_range(1, 2);
        if (n > int'(max_sect)) n = int'(max_sect);
        hit = (kind == FK_MATCH || kind == FK_CUT_IN_ROW) ? $urandom_range(0, n - 1) : -1;
        cnt = n;
        if (kind == FK_BAD_COUNT) begin
            if (max_sect == 16'hFFFF || $urandom_range(0, 1) == 0) cnt = 0;
            else cnt = $urandom_range(int'(max_sect) + 1, 65535);
        end
        if (kind == FK_NOISE) begin
            len = $urandom_range(1, 12);
            for (i = 0; i < len; i++) img.push_back(8'($urandom));
            if ($urandom_range(0, 1) == 1) img[0] = CHAR_M;
        end else begin
            for (i = 0; i < 64; i++) img.push_back(8'($urandom));
            img[0] = CHAR_M;
            img[1] = CHAR_Z;
            for (i = 0; i < 4; i++) img[60 + i] = 8'(h >> (8 * i));
            while (img.size() < h) img.push_back(8'($urandom));
            h = img.size() > h ? 64 : h;
            for (i = 0; i < 24; i++) begin
                case (i)
                    0:       v = CHAR_P;
                    1:       v = CHAR_E;
                    2, 3:    v = 8'h00;
                    6:       v = 8'(cnt);
                    7:       v = 8'(cnt >> 8);
                    20:      v = 8'(opt);
                    21:      v = 8'(opt >> 8);
                    default: v = 8'($urandom);
                endcase
                img.push_back(v);
            end
            for (i = 0; i < opt; i++) img.push_back(8'($urandom));
            row0 = img.size();
            for (r = 0; r < n; r++) begin
                for (b = 0; b < 40; b++) begin
                    if (b < 8) img.push_back(want_name[8*b +: 8]);
                    else img.push_back(8'($urandom));
                end
                if (r != hit) img[row0 + 40*r + $urandom_range(0, 7)] ^= nz_byte();
            end
            if (kind == FK_BAD_MZ) img[$urandom_range(0, 1)] ^= nz_byte();
            if (kind == FK_BAD_SIG) img[h + $urandom_range(0, 3)] ^= nz_byte();
            for (i = 0; i < 3; i++) img.push_back(8'($urandom));
            // files that decide early end on or a few bytes after the deciding byte
            case (kind)
                FK_CUT:        len = $urandom_range(1, img.size() - 1);
                FK_CUT_IN_ROW: len = $urandom_range(row0 + 40*hit + 1, row0 + 40*hit + 39);
                FK_BAD_MZ:     len = 2 + $urandom_range(0, 2);
                FK_SMALL_HDR:  len = 64 + $urandom_range(0, 2);
                FK_BAD_SIG:    len = h + 4 + $urandom_range(0, 2);
                FK_BAD_COUNT:  len = h + 24 + $urandom_range(0, 2);
                FK_MATCH:      len = row0 + 40*(hit + 1) + $urandom_range(0, 2);
                default:       len = img.size() - $urandom_range(0, 2);
            endcase
        end
        for (i = 0; i < len; i++)
            beat_q.push_back('{img[i], (i == len - 1), BY_MODEL, ST_FOUND});
        n_files++;
        while (beat_q.size() > 32) @(negedge aclk);
    endtask

    initial begin
        logic [63:0] names [5];
        logic [15:0] maxes [5];
        int ph, i;
        names[0] = 64'h0;                    maxes[0] = MAX_SECT_RST;
        names[1] = 64'hFFFF_FFFF_FFFF_FFFF;  maxes[1] = 16'd1;
        names[2] = {$urandom, $urandom};     maxes[2] = 16'hFFFF;
        names[3] = 64'h0000_0074_7865_742E;  maxes[3] = 16'd8;
        names[4] = 64'h0;                    maxes[4] = 16'd3;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (dir_rows[i]) beat_q.push_back(dir_rows[i]);

        for (ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                wait_drained();
                write_reg(CFG_WANTED_NAME, names[ph]);
                write_reg(CFG_MAX_SECTIONS, {48'h0, maxes[ph]});
                @(negedge aclk);
            end
            calm = (ph == 2);
            case (ph)
                0: begin
                    queue_file(FK_MATCH);
                    queue_file(FK_BAD_MZ);
                    queue_file(FK_NOISE);
                end
                1: begin
                    queue_file(FK_BAD_COUNT);
                    // long output stall while short files keep coming
                    hold_off = 400;
                    for (i = 0; i < 8; i++)
                        queue_file($urandom_range(0, 1) ? FK_BAD_MZ : FK_NOISE);
                end
                2: queue_file(FK_MISS);
                3: begin
                    queue_file(FK_BAD_SIG);
                    queue_file(FK_CUT);
                end
                default: begin
                    queue_file(FK_SMALL_HDR);
                    queue_file(FK_CUT_IN_ROW);
                end
            endcase
        end
        wait_drained();
        calm = 1'b0;

        $display("covered %0d files, %0d beats, %0d lookup results over 5 register settings",
                 n_files, n_beats, n_results);
        $display("mix: matches, misses, malformed headers, bad counts and truncated files");
        if (errors == 0 && pending_lookups.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d lookups never returned", errors, pending_lookups.size());
            $display("FAILURE");
        end
        $finish;
    end

endmodule
